[rtl/ecbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_pkg
// Shared types and constants for the equal-count bin statistics core:
// register map, result status codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ecbs_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned BinW      = 10;
  localparam int unsigned CountW    = 32;
  localparam int unsigned RemW      = 33;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OutDataW  = 272;

  localparam logic signed [ValueW-1:0] LlongMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] LlongMin = {1'b1, {(ValueW-1){1'b0}}};

  // Reset values of the configuration registers
  localparam logic [BinW-1:0]   NumBinsRst   = 10'd2;
  localparam logic [CountW-1:0] TotalRowsRst = 32'd3;

  // Register index (byte address / 4)
  typedef enum logic [0:0] {
    REG_NUM_BINS   = 1'b0,
    REG_TOTAL_ROWS = 1'b1
  } reg_idx_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_BIN_DONE = 2'd0,
    ST_BAD_CFG  = 2'd1,
    ST_BEYOND   = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_RUN,
    S_SIZE,
    S_MEAN_GO,
    S_MEAN
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    hold_en;       // capture the input value for later
    logic    acc_en;        // fold a value into the running bin
    logic    acc_src_hold;  // take that value from the hold register
    logic    set_size;      // latch rows per bin from the divider
    logic    div_start;     // launch the divider
    logic    div_sel_mean;  // 1: bin mean, 0: rows per bin
    logic    emit_status;   // load a status-only result
    status_e status_code;
    logic    emit_bin;      // load a finished bin result and close the bin
  } ecbs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cfg_bad;
    logic beyond;
    logic size_ready;
    logic done_next;
    logic div_busy;
    logic out_free;
  } ecbs_sts_t;

endpackage

[rtl/ecbs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_div
// Radix-2 restoring divider, 64-bit unsigned dividend by 32-bit divisor.
// One quotient bit per cycle; busy stays high from start until the last
// quotient bit is in, and the result holds until the next start.
// ----------------------------------------------------------------------------
module ecbs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [31:0] dvs_q;
  logic [31:0] rem_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh  = {rem_q, dvd_q[63]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Control: step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], ge};
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

[rtl/ecbs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_dp
// Datapath: stream and bin accumulators, bin-close detection, the shared
// divider and the result register on the master side.
// ----------------------------------------------------------------------------
module ecbs_dp #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ecbs_pkg::BinW-1:0]         num_bins_i,
  input  logic [ecbs_pkg::CountW-1:0]       total_rows_i,
  input  logic                              cfg_wr_i,
  input  ecbs_pkg::ecbs_cmd_t               cmd_i,
  output ecbs_pkg::ecbs_sts_t               sts_o,
  input  logic signed [ecbs_pkg::ValueW-1:0] value_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [ecbs_pkg::OutDataW-1:0]     m_data_o,
  output logic [ecbs_pkg::StatusW-1:0]      m_user_o
);

  // Stream state
  logic [31:0]        rpb_q;
  logic               size_ready_q;
  logic [9:0]         cur_bin_q;
  logic [31:0]        rows_in_bin_q;
  logic [31:0]        rows_seen_q;
  logic signed [63:0] min_q;
  logic signed [63:0] max_q;
  logic signed [63:0] sum_q;
  logic signed [63:0] hold_q;

  // Result register
  logic                           out_valid_q;
  logic [ecbs_pkg::OutDataW-1:0]  out_data_q;
  logic [ecbs_pkg::StatusW-1:0]   out_user_q;

  // Divider
  logic        div_busy;
  logic [63:0] div_quot;
  logic [31:0] div_rem;
  logic [63:0] div_dvd;
  logic [31:0] div_dvs;

  logic signed [63:0] acc_val;
  logic [31:0]        rpb_eff;
  logic               last_bin;
  logic               done_next;
  logic               cfg_bad;
  logic               out_free;
  logic               sum_neg;
  logic [63:0]        sum_mag;
  logic [63:0]        avg_q;
  logic [32:0]        avg_r;

  // Configuration check, end-of-column and bin-close detection
  always_comb begin
    cfg_bad  = (num_bins_i < 10'd2)
            || ({22'd0, num_bins_i} >= 32'(MAX_BINS))
            || (total_rows_i <= {22'd0, num_bins_i});
    rpb_eff  = size_ready_q ? rpb_q : div_quot[31:0];
    last_bin = ({1'b0, cur_bin_q} + 11'd1) >= {1'b0, num_bins_i};
    done_next = last_bin
              ? (({1'b0, rows_seen_q} + 33'd1) >= {1'b0, total_rows_i})
              : (({1'b0, rows_in_bin_q} + 33'd1) >= {1'b0, rpb_eff});
    out_free = !out_valid_q || m_ready_i;
    acc_val  = cmd_i.acc_src_hold ? hold_q : value_i;
  end

  // Divider operand select: rows per bin, or magnitude of the bin sum
  always_comb begin
    sum_neg = sum_q[63];
    sum_mag = sum_neg ? (64'd0 - sum_q) : sum_q;
    if (cmd_i.div_sel_mean) begin
      div_dvd = sum_mag;
      div_dvs = rows_in_bin_q;
    end else begin
      div_dvd = {32'd0, total_rows_i};
      div_dvs = {22'd0, num_bins_i};
    end
    avg_q = sum_neg ? (64'd0 - div_quot) : div_quot;
    avg_r = sum_neg ? (33'd0 - {1'b0, div_rem}) : {1'b0, div_rem};
  end

  ecbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Hold the first row of a stream while the bin size is computed
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_en) begin
      hold_q <= value_i;
    end
  end

  // Accumulate rows, close bins, restart on a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpb_q         <= '0;
      size_ready_q  <= 1'b0;
      cur_bin_q     <= '0;
      rows_in_bin_q <= '0;
      rows_seen_q   <= '0;
      min_q         <= ecbs_pkg::LlongMax;
      max_q         <= ecbs_pkg::LlongMin;
      sum_q         <= '0;
    end else if (cfg_wr_i) begin
      rpb_q         <= '0;
      size_ready_q  <= 1'b0;
      cur_bin_q     <= '0;
      rows_in_bin_q <= '0;
      rows_seen_q   <= '0;
      min_q         <= ecbs_pkg::LlongMax;
      max_q         <= ecbs_pkg::LlongMin;
      sum_q         <= '0;
    end else begin
      if (cmd_i.set_size) begin
        rpb_q        <= div_quot[31:0];
        size_ready_q <= 1'b1;
      end
      if (cmd_i.acc_en) begin
        if (acc_val < min_q) begin
          min_q <= acc_val;
        end
        if (acc_val > max_q) begin
          max_q <= acc_val;
        end
        sum_q         <= sum_q + acc_val;
        rows_in_bin_q <= rows_in_bin_q + 32'd1;
        rows_seen_q   <= rows_seen_q + 32'd1;
      end else if (cmd_i.emit_bin) begin
        if (!last_bin) begin
          cur_bin_q <= cur_bin_q + 10'd1;
        end
        rows_in_bin_q <= '0;
        min_q         <= ecbs_pkg::LlongMax;
        max_q         <= ecbs_pkg::LlongMin;
        sum_q         <= '0;
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.emit_bin) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      out_data_q <= '0;
      out_user_q <= cmd_i.status_code;
    end else if (cmd_i.emit_bin) begin
      out_data_q <= {5'd0, avg_r, avg_q, rows_in_bin_q, max_q, min_q, cur_bin_q};
      out_user_q <= ecbs_pkg::ST_BIN_DONE;
    end
  end

  always_comb begin
    sts_o.cfg_bad    = cfg_bad;
    sts_o.beyond     = rows_seen_q >= total_rows_i;
    sts_o.size_ready = size_ready_q;
    sts_o.done_next  = done_next;
    sts_o.div_busy   = div_busy;
    sts_o.out_free   = out_free;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = out_user_q;

`ifndef SYNTH
  // Never take more rows than the column holds
  a_rows_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q <= total_rows_i)
    else $error("rows_seen exceeds total_rows");

  // A bin never holds more rows than the stream has seen
  a_bin_within_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_in_bin_q <= rows_seen_q)
    else $error("rows_in_bin exceeds rows_seen");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_status || cmd_i.emit_bin) |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

[rtl/ecbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbs_ctrl
// Controller: accepts rows, sequences the bin-size and bin-mean divisions
// and decides when a result is loaded.
// ----------------------------------------------------------------------------
module ecbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  ecbs_pkg::ecbs_sts_t sts_i,
  output ecbs_pkg::ecbs_cmd_t cmd_o
);

  ecbs_pkg::ctrl_state_e state_q;
  ecbs_pkg::ctrl_state_e state_d;
  logic                  accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecbs_pkg::S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    accept    = 1'b0;
    unique case (state_q)
      ecbs_pkg::S_RUN: begin
        // A status result needs the output register; a plain row does not
        s_ready_o = !(sts_i.cfg_bad || sts_i.beyond) || sts_i.out_free;
        accept    = s_valid_i && s_ready_o;
        if (accept) begin
          priority if (sts_i.cfg_bad) begin
            cmd_o.emit_status = 1'b1;
            cmd_o.status_code = ecbs_pkg::ST_BAD_CFG;
          end else if (sts_i.beyond) begin
            cmd_o.emit_status = 1'b1;
            cmd_o.status_code = ecbs_pkg::ST_BEYOND;
          end else if (!sts_i.size_ready) begin
            cmd_o.hold_en   = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = ecbs_pkg::S_SIZE;
          end else begin
            cmd_o.acc_en = 1'b1;
            if (sts_i.done_next) begin
              state_d = ecbs_pkg::S_MEAN_GO;
            end
          end
        end
      end
      ecbs_pkg::S_SIZE: begin
        // Latch the bin size and, in the same cycle, fold in the held first row
        if (!sts_i.div_busy) begin
          cmd_o.set_size     = 1'b1;
          cmd_o.acc_en       = 1'b1;
          cmd_o.acc_src_hold = 1'b1;
          state_d = sts_i.done_next ? ecbs_pkg::S_MEAN_GO : ecbs_pkg::S_RUN;
        end
      end
      ecbs_pkg::S_MEAN_GO: begin
        cmd_o.div_start    = 1'b1;
        cmd_o.div_sel_mean = 1'b1;
        state_d            = ecbs_pkg::S_MEAN;
      end
      ecbs_pkg::S_MEAN: begin
        // Load the bin result once the mean is ready and the slot is free
        if (!sts_i.div_busy && sts_i.out_free) begin
          cmd_o.emit_bin = 1'b1;
          state_d        = ecbs_pkg::S_RUN;
        end
      end
      default: begin
        state_d = ecbs_pkg::S_RUN;
      end
    endcase
  end

`ifndef SYNTH
  // Rows are taken only while no division is in flight
  a_ready_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_ready_o |-> (state_q == ecbs_pkg::S_RUN))
    else $error("row accepted outside run state");

  // A bin result is loaded only after the mean division has finished
  a_emit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_bin |-> !sts_i.div_busy && $past(state_q) == ecbs_pkg::S_MEAN)
    else $error("bin result loaded while divider busy");

  // The mean division always follows its setup cycle
  a_mean_after_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecbs_pkg::S_MEAN_GO) |=> (state_q == ecbs_pkg::S_MEAN) && sts_i.div_busy)
    else $error("mean division not launched");
`endif

endmodule

[rtl/equal_count_bin_statistics_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_count_bin_statistics_core
// Equal-count binning of a sorted signed 64-bit column with per-bin minimum,
// maximum, row count and exact mean (quotient and remainder).
// ----------------------------------------------------------------------------
// Rows stream in on the slave side, one transfer per row, at one row per
// cycle while a bin is filling. The first row after reset or a register
// write is held while the shared 64-step divider works out rows per bin;
// closing a bin sets up the divider operands, runs the 64 divider steps
// for the mean and then loads the result. Status results for a bad
// configuration or a row past total_rows are loaded as the row is taken. One
// result waits in the output register; further rows that close no bin keep
// being taken while it waits. Writing either register restarts the column.
// ----------------------------------------------------------------------------
module equal_count_bin_statistics_core #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Row input; tdata: value[63:0]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  // Results; tdata: bin_index[9:0], min_value[73:10], max_value[137:74],
  // row_count[169:138], avg_quotient[233:170], avg_remainder[266:234], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [271:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [ecbs_pkg::BinW-1:0]   num_bins_q;
  logic [ecbs_pkg::CountW-1:0] total_rows_q;
  logic                        cfg_wr;
  ecbs_pkg::reg_idx_e          reg_idx;
  ecbs_pkg::ecbs_cmd_t         cmd;
  ecbs_pkg::ecbs_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_idx = ecbs_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q   <= ecbs_pkg::NumBinsRst;
      total_rows_q <= ecbs_pkg::TotalRowsRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ecbs_pkg::REG_NUM_BINS:   num_bins_q   <= pwdata[9:0];
        ecbs_pkg::REG_TOTAL_ROWS: total_rows_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      ecbs_pkg::REG_NUM_BINS:   prdata = {22'd0, num_bins_q};
      ecbs_pkg::REG_TOTAL_ROWS: prdata = total_rows_q;
      default:                  prdata = '0;
    endcase
  end

  ecbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ecbs_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_bins_i   (num_bins_q),
    .total_rows_i (total_rows_q),
    .cfg_wr_i     (cfg_wr),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (s_axis_tdata),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_user_o     (m_axis_tuser)
  );

endmodule

[tb/tb_equal_count_bin_statistics_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_equal_count_bin_statistics_core
// Self-checking bench for the equal-count bin statistics core. Sorted integer
// columns stream in under several bin layouts; an in-bench model of the
// binning tracks rows per bin, running minimum, maximum and wrapped sum, and
// predicts each finished bin (count and exact mean as quotient/remainder) or
// status result. Every result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_equal_count_bin_statistics_core;

  localparam int MaxBins      = 1024;
  localparam int CycleLimit   = 1000000;
  localparam int DrainLimit   = 5000;
  localparam int SettleCycles = 120;
  localparam int PrintLimit   = 40;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_e;

  // Shapes of generated columns
  typedef enum int {
    COL_SMALL,
    COL_LOW_END,
    COL_HIGH_END,
    COL_WIDE,
    COL_FLAT,
    COL_SHUFFLED
  } col_shape_e;

  typedef struct packed {
    ecbs_pkg::status_e  status;
    logic [9:0]         bin_index;
    logic signed [63:0] min_value;
    logic signed [63:0] max_value;
    logic [31:0]        row_count;
    logic signed [63:0] avg_quotient;
    logic [32:0]        avg_remainder;
  } bin_result_t;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [63:0]  s_tdata  = '0;
  logic         s_tready;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [271:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  equal_count_bin_statistics_core #(
    .MAX_BINS(MaxBins)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // Binning model state and layout
  logic [9:0]         lay_num_bins;
  logic [31:0]        lay_total_rows;
  logic [31:0]        rows_per_bin;
  bit                 size_ready;
  logic [9:0]         cur_bin;
  logic [31:0]        rows_in_bin;
  logic [31:0]        rows_seen;
  logic signed [63:0] run_min;
  logic signed [63:0] run_max;
  logic [63:0]        run_sum;

  bin_result_t pending_bins[$];
  int          err_count      = 0;
  int          rows_sent      = 0;
  int          bins_predicted = 0;
  int          cycle_count    = 0;
  bit          tx_gaps_on     = 1'b1;
  int          burst_left     = 0;
  rx_mode_e    rx_mode        = RX_ALWAYS;
  int          rx_hold        = 0;

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= PrintLimit) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic void clear_bin();
    rows_in_bin = '0;
    run_min     = ecbs_pkg::LlongMax;
    run_max     = ecbs_pkg::LlongMin;
    run_sum     = '0;
  endfunction

  function automatic void restart_column();
    rows_per_bin = '0;
    size_ready   = 1'b0;
    cur_bin      = '0;
    rows_seen    = '0;
    clear_bin();
  endfunction

  // Fold one row into the model; return 1 when the row yields a result
  function automatic bit fold_row(input logic signed [63:0] v, output bin_result_t res);
    logic [63:0] mag, quo, rem, cnt;
    bit          neg, last_bin, closes;
    res = '0;
    if (lay_num_bins < 2 || int'(lay_num_bins) >= MaxBins ||
        lay_total_rows <= 32'(lay_num_bins)) begin
      res.status = ecbs_pkg::ST_BAD_CFG;
      return 1'b1;
    end
    if (rows_seen >= lay_total_rows) begin
      res.status = ecbs_pkg::ST_BEYOND;
      return 1'b1;
    end
    if (!size_ready) begin
      rows_per_bin = lay_total_rows / 32'(lay_num_bins);
      size_ready   = 1'b1;
    end
    if (v < run_min) run_min = v;
    if (v > run_max) run_max = v;
    run_sum = run_sum + v;
    rows_in_bin++;
    rows_seen++;
    last_bin = (int'(cur_bin) + 1 >= int'(lay_num_bins));
    closes   = last_bin ? (rows_seen >= lay_total_rows) : (rows_in_bin >= rows_per_bin);
    if (!closes) return 1'b0;

    // Exact mean: divide the magnitude, then restore the sign of the sum
    neg = run_sum[63];
    mag = neg ? -run_sum : run_sum;
    cnt = {32'd0, rows_in_bin};
    quo = mag / cnt;
    rem = mag % cnt;
    if (neg) begin
      quo = -quo;
      rem = -rem;
    end
    res.status        = ecbs_pkg::ST_BIN_DONE;
    res.bin_index     = cur_bin;
    res.min_value     = run_min;
    res.max_value     = run_max;
    res.row_count     = rows_in_bin;
    res.avg_quotient  = quo;
    res.avg_remainder = rem[32:0];
    if (!last_bin) cur_bin++;
    clear_bin();
    bins_predicted++;
    return 1'b1;
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result receiver stall pattern
  always @(posedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS: begin
        m_tready <= 1'b1;
      end
      RX_RANDOM: begin
        m_tready <= ($urandom_range(0, 99) < 60);
      end
      RX_PERIODIC: begin
        m_tready <= (cycle_count % 11) >= 6;
      end
      default: begin
        if (rx_hold == 0) begin
          m_tready <= ~m_tready;
          rx_hold  <= $urandom_range(1, 20);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    bin_result_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.status        = ecbs_pkg::status_e'(m_tuser);
      got.bin_index     = m_tdata[9:0];
      got.min_value     = m_tdata[73:10];
      got.max_value     = m_tdata[137:74];
      got.row_count     = m_tdata[169:138];
      got.avg_quotient  = m_tdata[233:170];
      got.avg_remainder = m_tdata[266:234];
      if (pending_bins.size() == 0) begin
        report_error($sformatf("unexpected result, status %0d bin %0d",
                               got.status, got.bin_index));
      end else begin
        want = pending_bins.pop_front();
        if (got.status != want.status)
          report_error($sformatf("status: got %0d expected %0d", got.status, want.status));
        if (got.bin_index != want.bin_index)
          report_error($sformatf("bin_index: got %0d expected %0d",
                                 got.bin_index, want.bin_index));
        if (got.min_value != want.min_value)
          report_error($sformatf("min_value: got %0d expected %0d",
                                 got.min_value, want.min_value));
        if (got.max_value != want.max_value)
          report_error($sformatf("max_value: got %0d expected %0d",
                                 got.max_value, want.max_value));
        if (got.row_count != want.row_count)
          report_error($sformatf("row_count: got %0d expected %0d",
                                 got.row_count, want.row_count));
        if (got.avg_quotient != want.avg_quotient)
          report_error($sformatf("avg_quotient: got %0d expected %0d",
                                 got.avg_quotient, want.avg_quotient));
        if (got.avg_remainder != want.avg_remainder)
          report_error($sformatf("avg_remainder: got %h expected %h",
                                 got.avg_remainder, want.avg_remainder));
      end
    end
  end

  // Send one row; hold tvalid until the transfer, with random burst gaps
  task automatic send_row(input logic [63:0] v);
    bin_result_t res;
    int          gap;
    if (tx_gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk_i); while (!s_tready);
    rows_sent++;
    if (fold_row(v, res)) pending_bins.push_back(res);
  endtask

  // Drop tvalid, wait for every predicted result, then let the core settle
  task automatic drain_results();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_bins.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_bins.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", pending_bins.size()));
      pending_bins.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write a register, then read it back; no row is offered meanwhile
  task automatic cfg_write(input ecbs_pkg::reg_idx_e idx, input logic [31:0] data);
    logic [31:0] want;
    s_tvalid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {idx, 2'b00};
    pwdata   <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ecbs_pkg::REG_NUM_BINS: begin
        lay_num_bins = data[9:0];
        want         = {22'd0, data[9:0]};
      end
      default: begin
        lay_total_rows = data;
        want           = data;
      end
    endcase
    restart_column();
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != want)
      report_error($sformatf("readback of register %0d: got %h expected %h",
                             idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Apply a bin layout in random register order, garbage in unused bits
  task automatic set_layout(input logic [9:0] nb, input logic [31:0] total);
    logic [31:0] nb_word;
    drain_results();
    nb_word       = $urandom;
    nb_word[9:0]  = nb;
    if ($urandom_range(0, 1)) begin
      cfg_write(ecbs_pkg::REG_NUM_BINS, nb_word);
      cfg_write(ecbs_pkg::REG_TOTAL_ROWS, total);
    end else begin
      cfg_write(ecbs_pkg::REG_TOTAL_ROWS, total);
      cfg_write(ecbs_pkg::REG_NUM_BINS, nb_word);
    end
  endtask

  task automatic set_idling();
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    rx_mode    = rx_mode_e'($urandom_range(0, 3));
  endtask

  // Stream n rows of the given shape; ascending shapes saturate at the top
  task automatic send_column(input int n, input col_shape_e shape);
    logic [63:0] v, step, room;
    case (shape)
      COL_SMALL: begin
        v    = 64'($urandom_range(0, 2000)) - 64'd1000;
        step = 64'($urandom_range(0, 40));
      end
      COL_LOW_END: begin
        v    = ecbs_pkg::LlongMin + 64'($urandom_range(0, 1000));
        step = 64'($urandom_range(0, 1000));
      end
      COL_HIGH_END: begin
        v    = ecbs_pkg::LlongMax - 64'($urandom_range(0, 64));
        step = 64'($urandom_range(0, 8));
      end
      COL_FLAT: begin
        v    = {$urandom, $urandom};
        step = '0;
      end
      default: begin
        v    = {$urandom, $urandom};
        step = {$urandom, $urandom} >> $urandom_range(1, 63);
      end
    endcase
    for (int i = 0; i < n; i++) begin
      send_row(v);
      if (shape == COL_SHUFFLED) begin
        v = {$urandom, $urandom};
      end else begin
        room = ecbs_pkg::LlongMax - v;
        v    = (step > room) ? ecbs_pkg::LlongMax : v + step;
      end
    end
  endtask

  // Reset layout: two bins over three rows, then one row past the end
  task automatic test_reset_layout();
    set_idling();
    send_row(ecbs_pkg::LlongMin);
    send_row(64'd0);
    send_row(ecbs_pkg::LlongMax);
    send_row(64'd5);
  endtask

  // Layouts the core must reject
  task automatic test_bad_layout();
    cfg_write(ecbs_pkg::REG_NUM_BINS, 32'd0);
    send_row(64'd1);
    send_row(-64'sd1);
    cfg_write(ecbs_pkg::REG_NUM_BINS, 32'd1);
    send_row(64'd2);
    set_layout(10'd5, 32'd5);
    send_row(64'd3);
    cfg_write(ecbs_pkg::REG_TOTAL_ROWS, 32'd0);
    send_row(64'd4);
  endtask

  // Wrapping sums, negative means and the last bin taking the remainder rows
  task automatic test_sum_wrap_and_sign();
    set_idling();
    set_layout(10'd2, 32'd4);
    send_row(ecbs_pkg::LlongMax);
    send_row(ecbs_pkg::LlongMax);
    send_row(ecbs_pkg::LlongMin);
    send_row(ecbs_pkg::LlongMin + 64'd3);
    set_layout(10'd3, 32'd7);
    send_row(-64'sd7);
    send_row(-64'sd4);
    send_row(64'd1);
    send_row(64'd2);
    send_row(64'd3);
    send_row(64'd5);
    send_row(64'd9);
  endtask

  // Largest bin count and largest row total
  task automatic test_widest_layout();
    set_idling();
    set_layout(10'd1023, 32'd1024);
    send_column(40, col_shape_e'($urandom_range(0, 4)));
    set_idling();
    set_layout(10'd2, 32'hFFFF_FFFF);
    send_column(6, COL_WIDE);
    set_layout(10'd1023, 32'hFFFF_FFFF);
    send_column(6, COL_LOW_END);
  endtask

  // Random layouts, mostly complete sorted columns with random content
  task automatic test_random_columns();
    int         goal_rows, goal_bins, kind, nb, total, n;
    col_shape_e shape;
    goal_rows = rows_sent + 720;
    goal_bins = bins_predicted + 48;
    while (rows_sent < goal_rows || bins_predicted < goal_bins) begin
      set_idling();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // rejected layout, a few stray rows
        if ($urandom_range(0, 1)) begin
          nb    = $urandom_range(0, 1);
          total = $urandom;
        end else begin
          nb    = $urandom_range(2, 1023);
          total = $urandom_range(0, nb);
        end
        set_layout(10'(nb), 32'(total));
        send_column($urandom_range(1, 4), COL_SHUFFLED);
      end else if (kind < 14) begin
        // huge column, only its first rows
        nb    = $urandom_range(2, 1023);
        total = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
        set_layout(10'(nb), 32'(total));
        send_column($urandom_range(1, 16), col_shape_e'($urandom_range(0, 5)));
      end else begin
        nb    = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 6);
        total = nb + 1 + $urandom_range(0, nb * 5);
        set_layout(10'(nb), 32'(total));
        n = total;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, total);
        else if ($urandom_range(0, 3) == 0) n = total + $urandom_range(1, 3);
        shape = ($urandom_range(0, 9) == 0) ? COL_SHUFFLED : col_shape_e'($urandom_range(0, 4));
        send_column(n, shape);
      end
    end
  endtask

  initial begin
    lay_num_bins   = ecbs_pkg::NumBinsRst;
    lay_total_rows = ecbs_pkg::TotalRowsRst;
    restart_column();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_layout();
    test_bad_layout();
    test_sum_wrap_and_sign();
    test_widest_layout();
    test_random_columns();
    drain_results();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
